// ===== design/calendar_seconds_converter_assert.svh =====
// ----------------------------------------------------------------------------
// Calendar seconds converter assertion macros
// Shorthand for clocked implications used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_SECONDS_CONVERTER_ASSERT_SVH
`define CALENDAR_SECONDS_CONVERTER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define CSC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("calendar seconds converter check failed");

// next-cycle implication, disabled while in reset
`define CSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("calendar seconds converter check failed");

`endif

// ===== design/csc_pkg.sv =====
// ----------------------------------------------------------------------------
// csc_pkg
// Shared constants, calendar helper functions and the stage record type.
// ----------------------------------------------------------------------------
package csc_pkg;

    localparam logic [7:0]  YearFold    = 8'd136;
    localparam logic [16:0] SecsPerDay  = 17'd86400;
    localparam logic [16:0] SecsPerHour = 17'd3600;
    localparam logic [8:0]  DaysPerYear = 9'd365;

    localparam logic [8:0] MonthStart [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [15:0] days;
        logic [16:0] rem;
        logic [31:0] total;
    } t_span;

    function automatic logic f_is_leap(input logic [7:0] y);
        return (y[1:0] == 2'b00) && (y != 8'd100);
    endfunction

    // days from the epoch to the first of January of year y
    function automatic logic [15:0] f_year_start(input logic [7:0] y);
        logic [8:0]  q4;
        logic [15:0] base;
        q4   = ({1'b0, y} + 9'd3) >> 2;
        base = 16'(y) * 16'(DaysPerYear);
        return base + 16'(q4) - ((y > 8'd100) ? 16'd1 : 16'd0);
    endfunction

    function automatic logic [8:0] f_month_start(input logic [3:0] idx, input logic leap);
        return MonthStart[idx] + (((idx > 4'd1) && leap) ? 9'd1 : 9'd0);
    endfunction

endpackage

// ===== design/csc_date.sv =====
// ----------------------------------------------------------------------------
// csc_date
// Start date to seconds since the epoch, plus offset: three register stages.
// ----------------------------------------------------------------------------
module csc_date import csc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_start_year,
    input  logic [3:0]  i_start_month,
    input  logic [4:0]  i_start_day,
    input  logic [4:0]  i_start_hour,
    input  logic [5:0]  i_start_minute,
    input  logic [5:0]  i_start_second,
    input  logic [31:0] i_offset_seconds,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_total
);

    logic [2:0] r_v;
    logic [3:0] w_adv;

    logic [7:0]  w_yr;
    logic [3:0]  w_mo;
    logic [4:0]  w_doff;
    logic [15:0] n_days;
    logic [16:0] n_sod;
    logic [31:0] n_dsec;
    logic [31:0] n_total;

    logic [15:0] r_days;
    logic [16:0] r_sod;
    logic [31:0] r_off0;
    logic [31:0] r_dsec;
    logic [31:0] r_off1;
    logic [31:0] r_total;

    always_comb begin
        w_adv[3] = i_ready;
        for (int k = 2; k >= 0; k--) begin
            w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    end

    always_comb begin
        w_yr   = (i_start_year > YearFold) ? i_start_year - YearFold : i_start_year;
        if (i_start_month > 4'd12) begin
            w_mo = 4'd11;
        end else if (i_start_month == 4'd0) begin
            w_mo = 4'd0;
        end else begin
            w_mo = i_start_month - 4'd1;
        end
        w_doff = (i_start_day == 5'd0) ? 5'd0 : i_start_day - 5'd1;
        n_days = f_year_start(w_yr) + 16'(f_month_start(w_mo, f_is_leap(w_yr)))
               + 16'(w_doff);
        n_sod  = 17'(i_start_hour) * SecsPerHour + 17'(i_start_minute) * 17'd60
               + 17'(i_start_second);
        n_dsec  = 32'(r_days) * 32'(SecsPerDay) + 32'(r_sod);
        n_total = r_dsec + r_off1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) r_v[0] <= i_valid;
            if (w_adv[1]) r_v[1] <= r_v[0];
            if (w_adv[2]) r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_days <= n_days;
            r_sod  <= n_sod;
            r_off0 <= i_offset_seconds;
        end
        if (w_adv[1]) begin
            r_dsec <= n_dsec;
            r_off1 <= r_off0;
        end
        if (w_adv[2]) begin
            r_total <= n_total;
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_v[2];
    assign o_total = r_total;

endmodule

// ===== design/csc_split.sv =====
// ----------------------------------------------------------------------------
// csc_split
// Split the total into whole days and seconds of day by reciprocal multiply.
// ----------------------------------------------------------------------------
module csc_split import csc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_total,
    output logic        o_valid,
    input  logic        i_ready,
    output t_span       o_span
);

    localparam logic [25:0] RecipDay = 26'd50903317;

    logic [2:0] r_v;
    logic [3:0] w_adv;

    logic [50:0] w_prod;
    logic [15:0] n_q;
    logic [31:0] n_qm;
    logic [31:0] w_diff;
    t_span       n_span;

    logic [15:0] r_q0;
    logic [31:0] r_tot0;
    logic [15:0] r_q1;
    logic [31:0] r_qm;
    logic [31:0] r_tot1;
    t_span       r_span;

    always_comb begin
        w_adv[3] = i_ready;
        for (int k = 2; k >= 0; k--) begin
            w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    end

    always_comb begin
        w_prod = 51'(i_total[31:7]) * 51'(RecipDay);
        n_q    = w_prod[50:35];
        n_qm   = 32'(r_q0) * 32'(SecsPerDay);
        w_diff = r_tot1 - r_qm;
        n_span.total = r_tot1;
        if (w_diff >= 32'(SecsPerDay)) begin
            n_span.days = r_q1 + 16'd1;
            n_span.rem  = 17'(w_diff - 32'(SecsPerDay));
        end else begin
            n_span.days = r_q1;
            n_span.rem  = 17'(w_diff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) r_v[0] <= i_valid;
            if (w_adv[1]) r_v[1] <= r_v[0];
            if (w_adv[2]) r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_q0   <= n_q;
            r_tot0 <= i_total;
        end
        if (w_adv[1]) begin
            r_q1   <= r_q0;
            r_qm   <= n_qm;
            r_tot1 <= r_tot0;
        end
        if (w_adv[2]) begin
            r_span <= n_span;
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_v[2];
    assign o_span  = r_span;

endmodule

// ===== design/csc_cal.sv =====
// ----------------------------------------------------------------------------
// csc_cal
// Day count to year, month and day; seconds of day to hour, minute, second.
// ----------------------------------------------------------------------------
module csc_cal import csc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_span       i_span,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_total_seconds,
    output logic [7:0]  o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);

    localparam logic [15:0] RecipYear = 16'd45965;
    localparam logic [16:0] RecipHour = 17'd74566;
    localparam logic [12:0] RecipMin  = 13'd4370;

    logic [3:0] r_v;
    logic [4:0] w_adv;

    logic [31:0] w_yprod;
    logic [33:0] w_hprod;
    logic [24:0] w_mprod;
    logic [7:0]  n_y1;
    logic [4:0]  n_hr;
    logic [15:0] n_st;
    logic [15:0] n_stp;
    logic [11:0] n_rem2;
    logic [7:0]  n_y;
    logic [8:0]  n_doy;
    logic [5:0]  n_min;
    logic        w_leap;
    logic [3:0]  w_midx;
    logic [4:0]  n_day;
    logic [5:0]  n_sec;

    logic [7:0]  r_y1_0;
    logic [4:0]  r_hr0;
    logic [15:0] r_days0;
    logic [16:0] r_rem0;
    logic [31:0] r_tot0;

    logic [7:0]  r_y1_1;
    logic [15:0] r_st;
    logic [15:0] r_stp;
    logic [15:0] r_days1;
    logic [11:0] r_rem2_1;
    logic [4:0]  r_hr1;
    logic [31:0] r_tot1;

    logic [7:0]  r_y2;
    logic [8:0]  r_doy2;
    logic [5:0]  r_min2;
    logic [11:0] r_rem2_2;
    logic [4:0]  r_hr2;
    logic [31:0] r_tot2;

    logic [31:0] r_total_seconds;
    logic [7:0]  r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute;
    logic [5:0]  r_second;

    always_comb begin
        w_adv[4] = i_ready;
        for (int k = 3; k >= 0; k--) begin
            w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    end

    always_comb begin
        w_yprod = 32'(i_span.days) * 32'(RecipYear);
        n_y1    = w_yprod[31:24];
        w_hprod = 34'(i_span.rem) * 34'(RecipHour);
        n_hr    = w_hprod[32:28];

        n_st   = f_year_start(r_y1_0);
        n_stp  = f_year_start(r_y1_0 - 8'd1);
        n_rem2 = 12'(r_rem0 - 17'(r_hr0) * SecsPerHour);

        if (r_days1 < r_st) begin
            n_y   = r_y1_1 - 8'd1;
            n_doy = 9'(r_days1 - r_stp);
        end else begin
            n_y   = r_y1_1;
            n_doy = 9'(r_days1 - r_st);
        end
        w_mprod = 25'(r_rem2_1) * 25'(RecipMin);
        n_min   = w_mprod[23:18];

        w_leap = f_is_leap(r_y2);
        w_midx = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (r_doy2 >= f_month_start(4'(i), w_leap)) w_midx = 4'(i);
        end
        n_day = 5'(r_doy2 - f_month_start(w_midx, w_leap) + 9'd1);
        n_sec = 6'(r_rem2_2 - 12'(r_min2) * 12'd60);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) r_v[0] <= i_valid;
            if (w_adv[1]) r_v[1] <= r_v[0];
            if (w_adv[2]) r_v[2] <= r_v[1];
            if (w_adv[3]) r_v[3] <= r_v[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_y1_0  <= n_y1;
            r_hr0   <= n_hr;
            r_days0 <= i_span.days;
            r_rem0  <= i_span.rem;
            r_tot0  <= i_span.total;
        end
        if (w_adv[1]) begin
            r_y1_1   <= r_y1_0;
            r_st     <= n_st;
            r_stp    <= n_stp;
            r_days1  <= r_days0;
            r_rem2_1 <= n_rem2;
            r_hr1    <= r_hr0;
            r_tot1   <= r_tot0;
        end
        if (w_adv[2]) begin
            r_y2     <= n_y;
            r_doy2   <= n_doy;
            r_min2   <= n_min;
            r_rem2_2 <= r_rem2_1;
            r_hr2    <= r_hr1;
            r_tot2   <= r_tot1;
        end
        if (w_adv[3]) begin
            r_total_seconds <= r_tot2;
            r_year          <= r_y2;
            r_month         <= w_midx + 4'd1;
            r_day           <= n_day;
            r_hour          <= r_hr2;
            r_minute        <= r_min2;
            r_second        <= n_sec;
        end
    end

    assign o_ready         = w_adv[0];
    assign o_valid         = r_v[3];
    assign o_total_seconds = r_total_seconds;
    assign o_year          = r_year;
    assign o_month         = r_month;
    assign o_day           = r_day;
    assign o_hour          = r_hour;
    assign o_minute        = r_minute;
    assign o_second        = r_second;

endmodule

// ===== design/calendar_seconds_converter.sv =====
// ----------------------------------------------------------------------------
// Calendar seconds converter: start date plus offset to total and calendar date
// Register stages: date 3, split 3, cal 4. Throughput: one transaction per
// cycle while i_ready stays high; a stage advances when empty or when
// its successor advances. Reset: synchronous i_rst_n clears stage valid bits.
// ----------------------------------------------------------------------------
module calendar_seconds_converter import csc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_start_year,
    input  logic [3:0]  i_start_month,
    input  logic [4:0]  i_start_day,
    input  logic [4:0]  i_start_hour,
    input  logic [5:0]  i_start_minute,
    input  logic [5:0]  i_start_second,
    input  logic [31:0] i_offset_seconds,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_total_seconds,
    output logic [7:0]  o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);

    logic        w_d_valid;
    logic        w_d_ready;
    logic [31:0] w_d_total;
    logic        w_s_valid;
    logic        w_s_ready;
    t_span       w_s_span;

    csc_date u_date (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_start_year     (i_start_year),
        .i_start_month    (i_start_month),
        .i_start_day      (i_start_day),
        .i_start_hour     (i_start_hour),
        .i_start_minute   (i_start_minute),
        .i_start_second   (i_start_second),
        .i_offset_seconds (i_offset_seconds),
        .o_valid          (w_d_valid),
        .i_ready          (w_d_ready),
        .o_total          (w_d_total)
    );

    csc_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d_valid),
        .o_ready (w_d_ready),
        .i_total (w_d_total),
        .o_valid (w_s_valid),
        .i_ready (w_s_ready),
        .o_span  (w_s_span)
    );

    csc_cal u_cal (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_s_valid),
        .o_ready         (w_s_ready),
        .i_span          (w_s_span),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_total_seconds (o_total_seconds),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day           (o_day),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second)
    );

endmodule

// ===== design/csc_checker.sv =====
// ----------------------------------------------------------------------------
// csc_checker
// Port-level checks on the calendar seconds converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "calendar_seconds_converter_assert.svh"

module csc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_total_seconds,
    input logic [7:0]  o_year,
    input logic [3:0]  o_month,
    input logic [4:0]  o_day,
    input logic [4:0]  o_hour,
    input logic [5:0]  o_minute,
    input logic [5:0]  o_second
);

    `CSC_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable({o_total_seconds, o_day}))
    `CSC_ASSERT_IMPL(a_year_range, o_valid, o_year <= 8'd136 && o_day >= 5'd1)
    `CSC_ASSERT_IMPL(a_month_range, o_valid, o_month >= 4'd1 && o_month <= 4'd12)
    `CSC_ASSERT_IMPL(a_time_range, o_valid, o_hour < 5'd24 && o_minute < 6'd60 && o_second < 6'd60)
    `CSC_ASSERT_IMPL(a_feb_range, o_valid && o_month == 4'd2, o_day <= 5'd29)

endmodule

bind calendar_seconds_converter csc_checker u_csc_checker (.*);

// ===== tb/tb_calendar_seconds_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar seconds converter testbench
// Drives start dates with offsets through the valid/ready input. Each result
// is compared, field by field, with a local calendar predictor or a fixed
// expectation. Input goes in bursts with random gaps, and the output side
// stalls on its own pattern. The run starts with a table of directed rows.
// ----------------------------------------------------------------------------
module tb_calendar_seconds_converter;

    localparam int unsigned YearSecs    = 31536000;
    localparam int unsigned DaySecs     = 86400;
    localparam int unsigned HourSecs    = 3600;
    localparam int          RandomCount = 950;
    localparam int          IdleLimit   = 5000;

    typedef struct packed {
        logic [7:0]  yr;
        logic [3:0]  mo;
        logic [4:0]  dy;
        logic [4:0]  hr;
        logic [5:0]  mi;
        logic [5:0]  se;
        logic [31:0] off;
    } t_date_req;

    typedef struct packed {
        logic [31:0] total;
        logic [7:0]  yr;
        logic [3:0]  mo;
        logic [4:0]  dy;
        logic [4:0]  hr;
        logic [5:0]  mi;
        logic [5:0]  se;
    } t_date_res;

    typedef struct packed {
        t_date_req  req;
        logic       fixed;
        t_date_res  res;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_start_year;
    logic [3:0]  i_start_month;
    logic [4:0]  i_start_day;
    logic [4:0]  i_start_hour;
    logic [5:0]  i_start_minute;
    logic [5:0]  i_start_second;
    logic [31:0] i_offset_seconds;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_total_seconds;
    logic [7:0]  o_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [5:0]  o_second;

    t_date_res   pending_dates[$];
    t_date_req   stim_reqs[$];
    t_date_res   stim_fixed[$];
    bit          stim_has_fixed[$];
    int          fail_count;
    int          result_count;
    int          idle_cycles;
    bit          feed_done;

    calendar_seconds_converter u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_start_year     (i_start_year),
        .i_start_month    (i_start_month),
        .i_start_day      (i_start_day),
        .i_start_hour     (i_start_hour),
        .i_start_minute   (i_start_minute),
        .i_start_second   (i_start_second),
        .i_offset_seconds (i_offset_seconds),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_total_seconds  (o_total_seconds),
        .o_year           (o_year),
        .o_month          (o_month),
        .o_day            (o_day),
        .o_hour           (o_hour),
        .o_minute         (o_minute),
        .o_second         (o_second)
    );

    function automatic bit leap_since_2000(input int unsigned y);
        int unsigned full;
        full = y + 2000;
        return ((full % 4 == 0) && (full % 100 != 0)) || (full % 400 == 0);
    endfunction

    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        int unsigned lens[12];
        lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m == 1 && leap_since_2000(y)) begin
            return 29;
        end
        return lens[m];
    endfunction

    function automatic t_date_res convert_date(input t_date_req rq);
        t_date_res   r;
        int unsigned yr;
        int unsigned mo;
        int unsigned days;
        int unsigned rem;
        int unsigned m;
        int unsigned len;
        bit [31:0]   acc;
        yr  = rq.yr;
        mo  = rq.mo;
        acc = 0;
        if (yr > 136) begin
            yr = yr - 136;
        end
        for (int unsigned i = 0; i < yr; i++) begin
            acc += YearSecs + (leap_since_2000(i) ? DaySecs : 0);
        end
        if (mo > 12) begin
            mo = 12;
        end
        if (mo > 0) begin
            mo = mo - 1;
        end
        for (int unsigned i = 0; i < mo; i++) begin
            acc += month_days(i, yr) * DaySecs;
        end
        if (rq.dy > 0) begin
            acc += (rq.dy - 1) * DaySecs;
        end
        acc += rq.hr * HourSecs + rq.mi * 60 + rq.se;
        acc += rq.off;
        r.total = acc;
        days = acc / DaySecs;
        rem  = acc % DaySecs;
        yr   = 0;
        m    = 0;
        while (days >= 365) begin
            if (leap_since_2000(yr)) begin
                if (days >= 366) begin
                    days -= 366;
                end else begin
                    break;
                end
            end else begin
                days -= 365;
            end
            yr++;
        end
        while (days >= 28 && m < 12) begin
            len = month_days(m, yr);
            if (days >= len) begin
                days -= len;
            end else begin
                break;
            end
            m++;
        end
        if (m > 11) begin
            m = 11;
        end
        r.yr = yr[7:0];
        r.mo = 4'(m + 1);
        r.dy = 5'(days + 1);
        r.hr = 5'(rem / HourSecs);
        r.mi = 6'((rem % HourSecs) / 60);
        r.se = 6'((rem % HourSecs) % 60);
        return r;
    endfunction

    function automatic t_date_req mk_req(input int y, input int mo, input int d, input int h,
                                         input int mi, input int s, input bit [31:0] off);
        t_date_req r;
        r = '{yr: 8'(y), mo: 4'(mo), dy: 5'(d), hr: 5'(h), mi: 6'(mi), se: 6'(s), off: off};
        return r;
    endfunction

    function automatic t_date_res mk_res(input bit [31:0] t, input int y, input int mo,
                                         input int d, input int h, input int mi, input int s);
        t_date_res r;
        r = '{total: t, yr: 8'(y), mo: 4'(mo), dy: 5'(d), hr: 5'(h), mi: 6'(mi), se: 6'(s)};
        return r;
    endfunction

    function automatic t_date_req rand_req();
        t_date_req r;
        case ($urandom_range(0, 9))
            0: begin
                r = t_date_req'({2'($urandom), $urandom, $urandom});
            end
            1: begin
                r = mk_req($urandom_range(0, 136), $urandom_range(0, 12), $urandom_range(0, 31),
                           $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59),
                           $urandom);
            end
            2: begin
                r = mk_req($urandom_range(137, 255), $urandom_range(0, 15),
                           $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 63),
                           $urandom_range(0, 63), 32'($urandom_range(0, 1000000)));
            end
            default: begin
                r = mk_req($urandom_range(0, 136), $urandom_range(1, 12), $urandom_range(1, 28),
                           $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59),
                           ($urandom_range(0, 1) != 0) ? 32'd0
                                                        : 32'($urandom_range(0, 200000000)));
            end
        endcase
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // build directed rows then random ones
    initial begin
        t_dir_row rows[$];
        rows.push_back('{mk_req(0, 1, 1, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 1, 1, 0, 0, 0)});
        rows.push_back('{mk_req(0, 0, 0, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 1, 1, 0, 0, 0)});
        rows.push_back('{mk_req(0, 1, 1, 23, 59, 59, 0), 1'b1,
                         mk_res(86399, 0, 1, 1, 23, 59, 59)});
        rows.push_back('{mk_req(0, 1, 1, 0, 0, 0, 32'hFFFFFFFF), 1'b0, '0});
        rows.push_back('{mk_req(0, 1, 1, 0, 0, 1, 32'hFFFFFFFF), 1'b1,
                         mk_res(0, 0, 1, 1, 0, 0, 0)});
        rows.push_back('{mk_req(136, 12, 31, 23, 59, 59, 0), 1'b0, '0});
        rows.push_back('{mk_req(255, 15, 31, 31, 63, 63, 32'hFFFFFFFF), 1'b0, '0});
        rows.push_back('{mk_req(137, 1, 1, 0, 0, 0, 0), 1'b0, '0});
        rows.push_back('{mk_req(136, 13, 1, 0, 0, 0, 0), 1'b0, '0});
        rows.push_back('{mk_req(0, 2, 31, 0, 0, 0, 0), 1'b0, '0});
        rows.push_back('{mk_req(0, 2, 29, 0, 0, 0, 0), 1'b0, '0});
        rows.push_back('{mk_req(1, 2, 29, 0, 0, 0, 0), 1'b0, '0});
        rows.push_back('{mk_req(100, 2, 29, 12, 0, 0, 0), 1'b0, '0});
        rows.push_back('{mk_req(10, 5, 10, 31, 63, 63, 0), 1'b0, '0});
        rows.push_back('{mk_req(0, 12, 31, 0, 0, 0, 86400), 1'b0, '0});
        rows.push_back('{mk_req(0, 1, 1, 0, 0, 0, 32'hAAAAAAAA), 1'b0, '0});
        rows.push_back('{mk_req(170, 10, 21, 21, 42, 42, 32'h55555555), 1'b0, '0});
        rows.push_back('{mk_req(85, 5, 10, 10, 21, 21, 0), 1'b0, '0});
        foreach (rows[k]) begin
            stim_reqs.push_back(rows[k].req);
            stim_has_fixed.push_back(rows[k].fixed);
            stim_fixed.push_back(rows[k].res);
        end
        for (int k = 0; k < RandomCount; k++) begin
            stim_reqs.push_back(rand_req());
            stim_has_fixed.push_back(1'b0);
            stim_fixed.push_back('0);
        end
    end

    // sender: bursts with random gaps
    initial begin
        int        burst;
        int        gap;
        t_date_req rq;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_start_year     = '0;
        i_start_month    = '0;
        i_start_day      = '0;
        i_start_hour     = '0;
        i_start_minute   = '0;
        i_start_second   = '0;
        i_offset_seconds = '0;
        feed_done        = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (stim_reqs.size() > 0) begin
            burst = $urandom_range(1, 20);
            gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            while (burst > 0 && stim_reqs.size() > 0) begin
                rq = stim_reqs.pop_front();
                i_valid          <= 1'b1;
                i_start_year     <= rq.yr;
                i_start_month    <= rq.mo;
                i_start_day      <= rq.dy;
                i_start_hour     <= rq.hr;
                i_start_minute   <= rq.mi;
                i_start_second   <= rq.se;
                i_offset_seconds <= rq.off;
                do @(posedge i_clk); while (!o_ready);
                pending_dates.push_back(stim_has_fixed.pop_front() ? stim_fixed.pop_front()
                                        : convert_date(rq));
                if (stim_fixed.size() > stim_has_fixed.size()) begin
                    void'(stim_fixed.pop_front());
                end
                burst--;
            end
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid   <= 1'b0;
        feed_done <= 1'b1;
    end

    // receiver: stall pattern of its own
    initial begin
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            case ($urandom_range(0, 3))
                0: i_ready <= 1'b0;
                1: i_ready <= ($urandom_range(0, 7) != 0);
                default: i_ready <= 1'b1;
            endcase
        end
    end

    // result check and watchdog
    always @(posedge i_clk) begin
        t_date_res want;
        t_date_res got;
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_total_seconds, o_year, o_month, o_day, o_hour, o_minute, o_second};
            result_count <= result_count + 1;
            if (pending_dates.size() == 0) begin
                $display("%0t: unexpected transaction, actual %p", $time, got);
                fail_count <= fail_count + 1;
            end else begin
                want = pending_dates.pop_front();
                if (want.total !== got.total || want.yr !== got.yr || want.mo !== got.mo ||
                    want.dy !== got.dy || want.hr !== got.hr || want.mi !== got.mi ||
                    want.se !== got.se) begin
                    $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                    fail_count <= fail_count + 1;
                end
            end
        end
    end

    initial begin
        fail_count   = 0;
        result_count = 0;
        idle_cycles  = 0;
        @(posedge i_rst_n);
        while (!(feed_done && pending_dates.size() == 0) && idle_cycles < IdleLimit) begin
            @(posedge i_clk);
        end
        if (idle_cycles >= IdleLimit) begin
            $display("status: fail");
        end else begin
            repeat (20) @(posedge i_clk);
            $display("Checked %0d conversions: directed extremes, year fold, month and day",
                     result_count);
            $display("saturation, offset wrap and random dates under input gaps and stalls.");
            if (fail_count == 0 && pending_dates.size() == 0) begin
                $display("status: pass");
            end else begin
                $display("status: fail");
            end
        end
        $finish;
    end

endmodule
